// ===== src/hsv2grb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HSV to GRB pixel package
// Word types, channel source codes and fixed-point constants shared by the
// colour conversion pipeline.
// ----------------------------------------------------------------------------
package hsv2grb_pkg;

    // Hue in 1/64 degree: a full turn and one sextant.
    localparam logic [14:0] HUE_FULL    = 15'd23040;
    localparam logic [14:0] SECTOR_LEN  = 15'd3840;
    localparam logic [14:0] SECTOR_PAIR = 15'd7680;
    localparam logic [14:0] SECTOR_HALF = 15'd15360;
    localparam logic [14:0] SECTOR_3    = 15'd11520;
    localparam logic [14:0] SECTOR_5    = 15'd19200;

    // Reciprocal of 15 in 16 fractional bits, used with a +1 bias.
    localparam logic [12:0] RECIP_15 = 13'd4369;

    typedef struct packed {
        logic signed [16:0] hue;
        logic [8:0]         saturation;
        logic [8:0]         brightness;
    } t_hsv_word;

    typedef struct packed {
        logic [7:0] green_level;
        logic [7:0] red_level;
        logic [7:0] blue_level;
    } t_grb_word;

    // What a channel receives on top of the offset m.
    typedef enum logic [1:0] {
        PART_ZERO   = 2'd0,
        PART_CHROMA = 2'd1,
        PART_SECOND = 2'd2
    } t_part_sel;

endpackage
`default_nettype wire

// ===== src/hsv_to_grb_pixel_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A word accepted at the input passes through the stage 1 to stage 7 registers in
// order and is presented on the output port from the stage 7 register.
// Throughput: one word per cycle while the output is not stalled; each of the
// seven register stages holds one word and moves on as soon as the stage after
// it is free. Reset: synchronous, active low; it clears the stage valid bits only.
// The block keeps no colour state between words.
// ----------------------------------------------------------------------------
// HSV to GRB pixel converter
// Wraps the hue, forms chroma, secondary and offset terms in exact fixed
// point, and scales each channel to a saturated 8-bit level.
// ----------------------------------------------------------------------------
module hsv_to_grb_pixel_top (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire hsv2grb_pkg::t_hsv_word i_in_data,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output hsv2grb_pkg::t_grb_word  o_out_data
);

    localparam int NSTAGE = 7;

    logic [NSTAGE:1]   r_vld;
    logic [NSTAGE+1:1] stage_en;

    // Stage 1: hue wrap, products v*s and v*(256-s).
    logic [14:0]        r1_hue;
    logic [17:0]        r1_vs;
    logic signed [18:0] r1_a;
    // Stage 2: sextant and position within the sextant pair.
    logic [2:0]         r2_sector;
    logic [12:0]        r2_p;
    logic [17:0]        r2_vs;
    logic signed [18:0] r2_a;
    // Stage 3: per-channel multiplier of v*s and the offset term.
    logic [11:0]        r3_k [3];
    logic [17:0]        r3_vs;
    logic signed [30:0] r3_ma;
    // Stage 4: part products.
    logic [29:0]        r4_prod [3];
    logic signed [30:0] r4_ma;
    // Stage 5: channel numerators.
    logic signed [31:0] r5_num [3];
    // Stage 6: scaled numerators divided by 2^24.
    logic [11:0]        r6_t [3];
    logic [2:0]         r6_sat;
    // Stage 7: output word.
    hsv2grb_pkg::t_grb_word r7_out;

    logic signed [17:0] h_ext;
    logic signed [17:0] h_wrap;
    logic [14:0]        hue_c;
    logic [17:0]        vs_c;
    logic signed [9:0]  s_comp;
    logic signed [19:0] a_full;

    logic [2:0]         sector_c;
    logic [14:0]        base_c;

    logic [12:0]        kx_c;
    logic signed [30:0] a_ext;
    hsv2grb_pkg::t_part_sel sel_c [3];

    logic [29:0]        prod_c [3];
    logic signed [31:0] num_c [3];
    logic signed [39:0] n_ext [3];
    logic signed [39:0] n255_c [3];
    logic [14:0]        t15_c [3];
    logic [11:0]        t_c [3];
    logic [2:0]         sat_c;
    logic [12:0]        t1_c [3];
    logic [25:0]        q_prod [3];
    logic [7:0]         lvl_c [3];

    // Each stage moves when it is empty or the next stage moves.
    always_comb begin
        stage_en[NSTAGE+1] = i_out_ready;
        for (int k = NSTAGE; k >= 1; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign o_in_ready  = stage_en[1];
    assign o_out_valid = r_vld[NSTAGE];
    assign o_out_data  = r7_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NSTAGE; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1 ----------------
    always_comb begin
        h_ext = {i_in_data.hue[16], i_in_data.hue};
        if (h_ext < 18'sd0) begin
            h_wrap = h_ext + 18'sd23040;
        end else if (h_ext > 18'sd23040) begin
            h_wrap = h_ext - 18'sd23040;
        end else begin
            h_wrap = h_ext;
        end
        if (h_wrap < 18'sd0) begin
            hue_c = '0;
        end else if (h_wrap > 18'sd23040) begin
            hue_c = hsv2grb_pkg::HUE_FULL;
        end else begin
            hue_c = h_wrap[14:0];
        end
        vs_c   = {9'd0, i_in_data.saturation} * {9'd0, i_in_data.brightness};
        s_comp = 10'sd256 - $signed({1'b0, i_in_data.saturation});
        a_full = $signed({1'b0, i_in_data.brightness}) * s_comp;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r1_hue <= hue_c;
            r1_vs  <= vs_c;
            r1_a   <= a_full[18:0];
        end
    end

    // ---------------- stage 2 ----------------
    always_comb begin
        priority if (r1_hue < hsv2grb_pkg::SECTOR_LEN) begin
            sector_c = 3'd0;
        end else if (r1_hue < hsv2grb_pkg::SECTOR_PAIR) begin
            sector_c = 3'd1;
        end else if (r1_hue < hsv2grb_pkg::SECTOR_3) begin
            sector_c = 3'd2;
        end else if (r1_hue < hsv2grb_pkg::SECTOR_HALF) begin
            sector_c = 3'd3;
        end else if (r1_hue < hsv2grb_pkg::SECTOR_5) begin
            sector_c = 3'd4;
        end else if (r1_hue < hsv2grb_pkg::HUE_FULL) begin
            sector_c = 3'd5;
        end else begin
            sector_c = 3'd6;
        end
        unique case (sector_c[2:1])
            2'd0:    base_c = '0;
            2'd1:    base_c = hsv2grb_pkg::SECTOR_PAIR;
            2'd2:    base_c = hsv2grb_pkg::SECTOR_HALF;
            default: base_c = hsv2grb_pkg::HUE_FULL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r2_sector <= sector_c;
            r2_p      <= 13'(r1_hue - base_c);
            r2_vs     <= r1_vs;
            r2_a      <= r1_a;
        end
    end

    // ---------------- stage 3 ----------------
    // Secondary weight 3840 - |p - 3840|, folded into one subtract.
    always_comb begin
        if (r2_p >= 13'(hsv2grb_pkg::SECTOR_LEN)) begin
            kx_c = 13'(hsv2grb_pkg::SECTOR_PAIR) - r2_p;
        end else begin
            kx_c = r2_p;
        end
        a_ext = {{12{r2_a[18]}}, r2_a};
        unique case (r2_sector)
            3'd0: begin
                sel_c[0] = hsv2grb_pkg::PART_SECOND;
                sel_c[1] = hsv2grb_pkg::PART_CHROMA;
                sel_c[2] = hsv2grb_pkg::PART_ZERO;
            end
            3'd1: begin
                sel_c[0] = hsv2grb_pkg::PART_CHROMA;
                sel_c[1] = hsv2grb_pkg::PART_SECOND;
                sel_c[2] = hsv2grb_pkg::PART_ZERO;
            end
            3'd2: begin
                sel_c[0] = hsv2grb_pkg::PART_CHROMA;
                sel_c[1] = hsv2grb_pkg::PART_ZERO;
                sel_c[2] = hsv2grb_pkg::PART_SECOND;
            end
            3'd3: begin
                sel_c[0] = hsv2grb_pkg::PART_SECOND;
                sel_c[1] = hsv2grb_pkg::PART_ZERO;
                sel_c[2] = hsv2grb_pkg::PART_CHROMA;
            end
            3'd4: begin
                sel_c[0] = hsv2grb_pkg::PART_ZERO;
                sel_c[1] = hsv2grb_pkg::PART_SECOND;
                sel_c[2] = hsv2grb_pkg::PART_CHROMA;
            end
            default: begin
                // Last sextant, including a hue of exactly a full turn.
                sel_c[0] = hsv2grb_pkg::PART_ZERO;
                sel_c[1] = hsv2grb_pkg::PART_CHROMA;
                sel_c[2] = hsv2grb_pkg::PART_SECOND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            for (int c = 0; c < 3; c++) begin
                unique case (sel_c[c])
                    hsv2grb_pkg::PART_CHROMA: r3_k[c] <= hsv2grb_pkg::SECTOR_LEN[11:0];
                    hsv2grb_pkg::PART_SECOND: r3_k[c] <= kx_c[11:0];
                    default:                  r3_k[c] <= '0;
                endcase
            end
            r3_vs <= r2_vs;
            r3_ma <= (a_ext <<< 12) - (a_ext <<< 8);
        end
    end

    // ---------------- stage 4 ----------------
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod_c[c] = {12'd0, r3_vs} * {18'd0, r3_k[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            for (int c = 0; c < 3; c++) begin
                r4_prod[c] <= prod_c[c];
            end
            r4_ma <= r3_ma;
        end
    end

    // ---------------- stage 5 ----------------
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            num_c[c] = {r4_ma[30], r4_ma} + $signed({2'b00, r4_prod[c]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            for (int c = 0; c < 3; c++) begin
                r5_num[c] <= num_c[c];
            end
        end
    end

    // ---------------- stage 6 ----------------
    // Scale by 255 and drop the 2^24 part of the 15 * 2^24 denominator.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_ext[c]  = {{8{r5_num[c][31]}}, r5_num[c]};
            n255_c[c] = (n_ext[c] <<< 8) - n_ext[c];
            t15_c[c]  = n255_c[c][38:24];
            if (r5_num[c][31] || (r5_num[c] == 32'sd0)) begin
                t_c[c]   = '0;
                sat_c[c] = 1'b0;
            end else if (t15_c[c] >= hsv2grb_pkg::SECTOR_LEN) begin
                t_c[c]   = '0;
                sat_c[c] = 1'b1;
            end else begin
                t_c[c]   = t15_c[c][11:0];
                sat_c[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            for (int c = 0; c < 3; c++) begin
                r6_t[c] <= t_c[c];
            end
            r6_sat <= sat_c;
        end
    end

    // ---------------- stage 7 ----------------
    // Division by 15 as (t + 1) * 4369 / 2^16, exact for t below 3840.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            t1_c[c]   = {1'b0, r6_t[c]} + 13'd1;
            q_prod[c] = {13'd0, t1_c[c]} * {13'd0, hsv2grb_pkg::RECIP_15};
            lvl_c[c]  = r6_sat[c] ? 8'd255 : q_prod[c][23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[7]) begin
            r7_out.green_level <= lvl_c[0];
            r7_out.red_level   <= lvl_c[1];
            r7_out.blue_level  <= lvl_c[2];
        end
    end

    // ---------------- checks ----------------
    a_full_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while every stage is full and stalled");

    a_weight_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> ((r3_k[0] <= hsv2grb_pkg::SECTOR_LEN[11:0])
                   && (r3_k[1] <= hsv2grb_pkg::SECTOR_LEN[11:0])
                   && (r3_k[2] <= hsv2grb_pkg::SECTOR_LEN[11:0])))
        else $error("channel weight beyond one sextant");

    a_sat_level : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[6] && stage_en[7] && r6_sat[0]) |=> (o_out_data.green_level == 8'd255))
        else $error("saturated green channel not at full level");

    a_neg_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && stage_en[6] && (r5_num[1] <= 32'sd0))
        |=> ((r6_t[1] == 12'd0) && !r6_sat[1]))
        else $error("non-positive red sum did not clear to zero");

endmodule
`default_nettype wire
